// ----- rtl/core/voice_endpoint_controller_defines.svh -----
// ----------------------------------------------------------------------------
// Voice endpoint controller assertion macros
// Shared helpers for the port-level checks.
// ----------------------------------------------------------------------------
`ifndef VOICE_ENDPOINT_CONTROLLER_DEFINES_SVH
`define VOICE_ENDPOINT_CONTROLLER_DEFINES_SVH

// same-cycle implication, clocked on clk, off during rst
`define VEC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("voice endpoint check failed");

// next-cycle implication
`define VEC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("voice endpoint check failed");

`endif

// ----- rtl/core/vec_pkg.sv -----
// ----------------------------------------------------------------------------
// vec_pkg
// Types, codes and constants of the voice endpoint controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vec_pkg;

  localparam int HANDLE_W          = 16;
  localparam int CNT_W             = 16;
  localparam int CFG_W             = 16;
  localparam int PREROLL_LIMIT_DEF = 31;

  localparam logic [CNT_W-1:0] CFG_RST_START_LIMIT    = 16'd150;
  localparam logic [CNT_W-1:0] CFG_RST_DONE_SILENCE   = 16'd50;
  localparam logic [CNT_W-1:0] CFG_RST_VOICE_ONSET    = 16'd3;
  localparam logic [CNT_W-1:0] CFG_RST_LISTEN_TIMEOUT = 16'd1000;

  localparam logic       FUNC_WAKE  = 1'b1;
  localparam logic [1:0] VAD_SILENT = 2'd0;
  localparam logic [1:0] VAD_VOICE  = 2'd1;

  typedef enum logic [1:0] {
    MODE_WAITING   = 2'd0,
    MODE_WOKE      = 2'd1,
    MODE_LISTENING = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    EV_WAKE  = 2'd0,
    EV_FRAME = 2'd1,
    EV_DONE  = 2'd2
  } evkind_t;

  typedef enum logic [1:0] {
    REG_START_LIMIT    = 2'd0,
    REG_DONE_SILENCE   = 2'd1,
    REG_VOICE_ONSET    = 2'd2,
    REG_LISTEN_TIMEOUT = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WAKE,
    ST_REPLAY,
    ST_FRAME,
    ST_DONE
  } ctl_state_t;

  typedef struct packed {
    logic [CNT_W-1:0] start_limit;
    logic [CNT_W-1:0] done_silence;
    logic [CNT_W-1:0] voice_onset;
    logic [CNT_W-1:0] listen_timeout;
  } cfg_t;

  typedef struct packed {
    logic       frame_step;
    logic       enter_woke;
    logic [1:0] vad;
  } trk_cmd_t;

  typedef struct packed {
    logic done;
    logic heard;
  } trk_res_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

endpackage

// ----- rtl/core/voice_endpoint_controller.sv -----
// ----------------------------------------------------------------------------
// voice_endpoint_controller
// Speech endpointing: pre-roll ring in RAM, wake replay, frame forwarding and
// threshold tracking over waiting, woke and listening modes.
// ----------------------------------------------------------------------------
// channel  | handshake            | payload
// input    | in_valid / in_stall  | func, frame_handle, wake_hit, vad_verdict
// output   | out_valid / out_stall| event_kind, out_handle, speech_heard,
//          |                      | mode_after, last
// config   | cfg_we               | cfg_index, cfg_data
//
// Wake request or buffered frame: no output beat. Forwarded frame: a frame
// beat, then a done beat if done. Wake hit: a wake beat, then N buffered
// frames (at most PREROLL_LIMIT+1), one beat per cycle unless out_stall holds
// it, from the single read port of the pre-roll RAM. rst is synchronous and
// clears control state; the RAM needs no clearing. out_stall holds the output
// register; in_stall is high until the item's last beat, if any, is loaded.
`timescale 1ns / 1ps

module voice_endpoint_controller #(
  parameter int PREROLL_LIMIT = vec_pkg::PREROLL_LIMIT_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         func,
  input  logic [vec_pkg::HANDLE_W-1:0] frame_handle,
  input  logic                         wake_hit,
  input  logic [1:0]                   vad_verdict,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   event_kind,
  output logic [vec_pkg::HANDLE_W-1:0] out_handle,
  output logic                         speech_heard,
  output logic [1:0]                   mode_after,
  output logic                         last,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [vec_pkg::CFG_W-1:0]    cfg_data
);

  import vec_pkg::*;

  localparam int CAP = PREROLL_LIMIT + 1;
  localparam int AW  = $clog2(CAP);
  localparam int FW  = $clog2(CAP + 1);
  localparam logic [FW-1:0] CAP_F  = FW'(CAP);
  localparam logic [FW-1:0] LAST_F = FW'(CAP - 1);
  localparam logic [FW-1:0] ONE_F  = FW'(1);
  localparam logic [AW-1:0] LAST_A = AW'(CAP - 1);
  localparam logic [FW:0]   CAP_S  = (FW+1)'(CAP);

  ctl_state_t state, state_next;
  cfg_t       cfg;
  trk_cmd_t   cmd;
  trk_res_t   res;
  mode_t      mode;

  logic [AW-1:0] head, head_next, head_plus, push_head;
  logic [FW-1:0] fill, fill_next, push_fill;
  logic [FW:0]   push_sum;
  logic          full, slot_free;

  logic                it_func, it_hit;
  logic [HANDLE_W-1:0] it_handle;
  logic [1:0]          it_vad;
  logic                pend_done, pend_heard;

  logic                wr_en, rd_en;
  logic [AW-1:0]       wr_addr, rd_addr;
  logic [HANDLE_W-1:0] rd_data;

  logic                ld, ld_heard, ld_last;
  evkind_t             ld_kind;
  logic [HANDLE_W-1:0] ld_handle;

  vec_ram #(
    .DEPTH (CAP),
    .AW    (AW),
    .DW    (HANDLE_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (it_handle),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  vec_track u_track (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .cmd  (cmd),
    .mode (mode),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_limit    <= CFG_RST_START_LIMIT;
      cfg.done_silence   <= CFG_RST_DONE_SILENCE;
      cfg.voice_onset    <= CFG_RST_VOICE_ONSET;
      cfg.listen_timeout <= CFG_RST_LISTEN_TIMEOUT;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_START_LIMIT:    cfg.start_limit    <= cfg_data;
        REG_DONE_SILENCE:   cfg.done_silence   <= cfg_data;
        REG_VOICE_ONSET:    cfg.voice_onset    <= cfg_data;
        REG_LISTEN_TIMEOUT: cfg.listen_timeout <= cfg_data;
      endcase
    end
  end

  // ring push: drop oldest when full, write at head + fill
  assign head_plus = (head == LAST_A) ? '0 : head + 1'b1;
  assign full      = (fill == CAP_F);
  assign push_head = full ? head_plus : head;
  assign push_fill = full ? LAST_F : fill;
  assign push_sum  = (FW+1)'(push_head) + (FW+1)'(push_fill);
  assign wr_addr   = (push_sum >= CAP_S) ? AW'(push_sum - CAP_S) : AW'(push_sum);

  assign slot_free = !out_valid || !out_stall;
  assign in_stall  = (state != ST_IDLE);

  always_comb begin
    state_next     = state;
    head_next      = head;
    fill_next      = fill;
    wr_en          = 1'b0;
    rd_en          = 1'b0;
    rd_addr        = head;
    cmd            = '0;
    cmd.vad        = it_vad;
    ld             = 1'b0;
    ld_kind        = EV_FRAME;
    ld_handle      = '0;
    ld_heard       = 1'b0;
    ld_last        = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (it_func == FUNC_WAKE) begin
          cmd.enter_woke = (mode == MODE_WAITING);
          state_next     = ST_IDLE;
        end else if (mode == MODE_WAITING) begin
          wr_en     = 1'b1;
          head_next = push_head;
          fill_next = push_fill + ONE_F;
          if (it_hit) begin
            cmd.enter_woke = 1'b1;
            state_next     = ST_WAKE;
          end else begin
            state_next = ST_IDLE;
          end
        end else begin
          cmd.frame_step = 1'b1;
          state_next     = ST_FRAME;
        end
      end
      ST_WAKE: begin
        rd_en = 1'b1;
        if (slot_free) begin
          ld         = 1'b1;
          ld_kind    = EV_WAKE;
          state_next = ST_REPLAY;
        end
      end
      ST_REPLAY: begin
        if (slot_free) begin
          ld        = 1'b1;
          ld_kind   = EV_FRAME;
          ld_handle = rd_data;
          ld_last   = (fill == ONE_F);
          head_next = head_plus;
          fill_next = fill - ONE_F;
          if (fill == ONE_F) begin
            state_next = ST_IDLE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = head_plus;
          end
        end
      end
      ST_FRAME: begin
        if (slot_free) begin
          ld         = 1'b1;
          ld_kind    = EV_FRAME;
          ld_handle  = it_handle;
          ld_last    = !pend_done;
          state_next = pend_done ? ST_DONE : ST_IDLE;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          ld         = 1'b1;
          ld_kind    = EV_DONE;
          ld_heard   = pend_heard;
          ld_last    = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head      <= '0;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      fill  <= fill_next;
      if (ld) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      it_func   <= func;
      it_handle <= frame_handle;
      it_hit    <= wake_hit;
      it_vad    <= vad_verdict;
    end
    if (state == ST_EXEC) begin
      pend_done  <= res.done;
      pend_heard <= res.heard;
    end
    if (ld) begin
      event_kind   <= ld_kind;
      out_handle   <= ld_handle;
      speech_heard <= ld_heard;
      mode_after   <= mode;
      last         <= ld_last;
    end
  end

endmodule

// ----- rtl/core/vec_ram.sv -----
// ----------------------------------------------------------------------------
// vec_ram
// Pre-roll frame store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vec_ram #(
  parameter int DEPTH = vec_pkg::PREROLL_LIMIT_DEF + 1,
  parameter int AW    = $clog2(DEPTH),
  parameter int DW    = vec_pkg::HANDLE_W
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/core/vec_track.sv -----
// ----------------------------------------------------------------------------
// vec_track
// Mode register and saturating frame, silence and voice counters.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vec_track (
  input  logic              clk,
  input  logic              rst,
  input  vec_pkg::cfg_t     cfg,
  input  vec_pkg::trk_cmd_t cmd,
  output vec_pkg::mode_t    mode,
  output vec_pkg::trk_res_t res
);

  import vec_pkg::*;

  mode_t            mode_next;
  logic [CNT_W-1:0] frame_total, frame_total_next;
  logic [CNT_W-1:0] silence_run, silence_run_next;
  logic [CNT_W-1:0] voice_tally, voice_tally_next;
  logic [CNT_W-1:0] ft_inc, sr_inc, vt_inc, sr_new;

  assign ft_inc = sat_inc(frame_total);
  assign sr_inc = sat_inc(silence_run);
  assign vt_inc = sat_inc(voice_tally);

  always_comb begin
    sr_new = (cmd.vad == VAD_SILENT) ? sr_inc :
             (cmd.vad == VAD_VOICE)  ? '0     : silence_run;
  end

  always_comb begin
    mode_next        = mode;
    frame_total_next = frame_total;
    silence_run_next = silence_run;
    voice_tally_next = voice_tally;
    res              = '0;
    if (cmd.enter_woke) begin
      mode_next        = MODE_WOKE;
      frame_total_next = '0;
      silence_run_next = '0;
      voice_tally_next = '0;
    end else if (cmd.frame_step) begin
      frame_total_next = ft_inc;
      silence_run_next = sr_new;
      unique case (mode)
        MODE_WOKE: begin
          if (cmd.vad == VAD_VOICE) begin
            voice_tally_next = vt_inc;
          end
          if (cmd.vad == VAD_VOICE && vt_inc >= cfg.voice_onset) begin
            mode_next        = MODE_LISTENING;
            frame_total_next = '0;
            silence_run_next = '0;
            voice_tally_next = '0;
          end else if (ft_inc >= cfg.start_limit) begin
            res.done         = 1'b1;
            mode_next        = MODE_WAITING;
            frame_total_next = '0;
            silence_run_next = '0;
            voice_tally_next = '0;
          end
        end
        MODE_LISTENING: begin
          if (sr_new >= cfg.done_silence || ft_inc >= cfg.listen_timeout) begin
            res.done         = 1'b1;
            res.heard        = 1'b1;
            mode_next        = MODE_WAITING;
            frame_total_next = '0;
            silence_run_next = '0;
            voice_tally_next = '0;
          end
        end
        MODE_WAITING: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_WAITING;
      frame_total <= '0;
      silence_run <= '0;
      voice_tally <= '0;
    end else begin
      mode        <= mode_next;
      frame_total <= frame_total_next;
      silence_run <= silence_run_next;
      voice_tally <= voice_tally_next;
    end
  end

endmodule

// ----- rtl/core/vec_checks.sv -----
// ----------------------------------------------------------------------------
// vec_checks
// Port-level checks on the voice endpoint controller, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "voice_endpoint_controller_defines.svh"

module vec_checks (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [1:0]                   event_kind,
  input logic [vec_pkg::HANDLE_W-1:0] out_handle,
  input logic                         speech_heard,
  input logic [1:0]                   mode_after,
  input logic                         last
);

  import vec_pkg::*;

  // stalled beat holds
  `VEC_ASSERT_NXT(a_out_hold, out_valid && out_stall,
                  out_valid && $stable(out_handle) && $stable(event_kind) && $stable(last))

  // one item in flight at a time
  `VEC_ASSERT_NXT(a_in_busy, in_valid && !in_stall, in_stall)

  // done closes the item and returns to waiting
  `VEC_ASSERT_IMP(a_done_end, out_valid && event_kind == EV_DONE,
                  last && mode_after == MODE_WAITING && out_handle == '0)

  // wake event always precedes its replay, mode woke
  `VEC_ASSERT_IMP(a_wake_first, out_valid && event_kind == EV_WAKE,
                  !last && mode_after == MODE_WOKE && out_handle == '0 && !speech_heard)

  // frames never claim speech
  `VEC_ASSERT_IMP(a_frame_flag, out_valid && event_kind == EV_FRAME, !speech_heard)

endmodule

bind voice_endpoint_controller vec_checks u_vec_checks (.*);
